// ===== sv/gbn_pkg.sv =====
// Shared types and codes for the go-back-N window engine.
package gbn_pkg;

  // Event codes on the input channel
  typedef enum logic [1:0] {
    CMD_PKT     = 2'd0,
    CMD_FRAME   = 2'd1,
    CMD_CKERR   = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  // Result kinds on the output channel
  typedef enum logic [2:0] {
    KIND_SEND    = 3'd0,
    KIND_DELIVER = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_STATUS  = 3'd3,
    KIND_DROP    = 3'd4
  } kind_t;

  // Sequence number width (eight numbers in the space)
  localparam int SEQ_W = 3;
  // Width of the result payload field
  localparam int OUT_PAY_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic emit_head;
    logic emit_walk;
    logic last;
  } gbn_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic             head_pend;
    logic [SEQ_W-1:0] walk_left;
  } gbn_sts_t;

endpackage

// ===== sv/gbn_ctrl.sv =====
// Controller state machine: event intake and result sequencing.
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  gbn_sts_t sts,
  output gbn_ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Take a new event only when idle
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequence one result per cycle while the output register has room
  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sts.head_pend) begin
            ctl.emit_head = 1'b1;
            ctl.last      = (sts.walk_left == '0);
          end else begin
            ctl.emit_walk = 1'b1;
            ctl.last      = (sts.walk_left == SEQ_W'(1));
          end
          if (ctl.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // While running there is always at least one result still to produce
  a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (sts.head_pend || (sts.walk_left != '0)))
    else $error("controller running with no pending result");

  // A result is loaded only when the previous one has left or is leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit_head || ctl.emit_walk) |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== sv/gbn_dp.sv =====
// Datapath: window pointers, packet store, event planning and output register.
module gbn_dp
  import gbn_pkg::*;
#(
  parameter int EFF_WIN = 7,
  parameter int STORE_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gbn_ctl_t             ctl,
  output gbn_sts_t             sts,
  input  logic [1:0]           in_cmd,
  input  logic [31:0]          in_payload,
  input  logic [SEQ_W-1:0]     in_frame_seq,
  input  logic [SEQ_W-1:0]     in_frame_ack,
  output logic [2:0]           out_kind,
  output logic [SEQ_W-1:0]     out_seq,
  output logic [SEQ_W-1:0]     out_ack,
  output logic [OUT_PAY_W-1:0] out_payload,
  output logic                 out_network_enable,
  output logic                 out_last
);

  localparam logic [SEQ_W-1:0] EFF3 = SEQ_W'(EFF_WIN);
  localparam int DEPTH = 1 << SEQ_W;

  // True when b lies circularly in [a, c)
  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  // Window state
  logic [SEQ_W-1:0] nts_r, nts_nxt;
  logic [SEQ_W-1:0] old_r, old_nxt;
  logic [SEQ_W-1:0] exp_r, exp_nxt;
  logic [SEQ_W-1:0] cnt_r, cnt_nxt;

  // Plan of the current event
  logic             head_pend_r, head_pend_nxt;
  kind_t            head_kind_r, head_kind_nxt;
  logic [SEQ_W-1:0] head_seq_r, head_seq_nxt;
  logic [STORE_W-1:0] head_pay_r, head_pay_nxt;
  kind_t            walk_kind_r, walk_kind_nxt;
  logic [SEQ_W-1:0] walk_ptr_r, walk_ptr_nxt;
  logic [SEQ_W-1:0] walk_left_r, walk_left_nxt;
  logic [SEQ_W-1:0] ack_r, ack_nxt;
  logic             en_r, en_nxt;

  // Packet store
  logic [STORE_W-1:0] mem [DEPTH];
  logic [STORE_W-1:0] rd_data_r;
  logic               wr_en;

  // Output register
  kind_t              out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]   out_seq_r, out_seq_nxt;
  logic [SEQ_W-1:0]   out_ack_r, out_ack_nxt;
  logic [OUT_PAY_W-1:0] out_pay_r, out_pay_nxt;
  logic               out_en_r, out_last_r;

  logic [STORE_W-1:0] pay_m;
  logic [SEQ_W-1:0]   span;
  logic [SEQ_W-1:0]   rel;
  logic               dlv;
  logic               full;

  assign pay_m = in_payload[STORE_W-1:0];
  assign span  = in_frame_ack - old_r;
  assign dlv   = (in_frame_seq == exp_r);
  assign full  = (cnt_r >= EFF3);
  // Frames released by the ack: the smaller of the buffered count and one more than the span
  assign rel   = ((cnt_r != '0) && in_window(old_r, in_frame_ack, nts_r)) ?
                 ((cnt_r > span) ? span + SEQ_W'(1) : cnt_r) : '0;

  assign sts.head_pend = head_pend_r;
  assign sts.walk_left = walk_left_r;

  // Plan the event and advance the window at accept; step the plan on emit
  always_comb begin
    nts_nxt       = nts_r;
    old_nxt       = old_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    head_pend_nxt = head_pend_r;
    head_kind_nxt = head_kind_r;
    head_seq_nxt  = head_seq_r;
    head_pay_nxt  = head_pay_r;
    walk_kind_nxt = walk_kind_r;
    walk_ptr_nxt  = walk_ptr_r;
    walk_left_nxt = walk_left_r;
    ack_nxt       = ack_r;
    en_nxt        = en_r;
    wr_en         = 1'b0;
    if (ctl.accept) begin
      head_pend_nxt = 1'b0;
      head_kind_nxt = KIND_STATUS;
      head_seq_nxt  = '0;
      head_pay_nxt  = '0;
      walk_kind_nxt = KIND_SEND;
      walk_ptr_nxt  = old_r;
      walk_left_nxt = '0;
      ack_nxt       = exp_r - SEQ_W'(1);
      unique case (cmd_t'(in_cmd))
        CMD_PKT: begin
          head_pend_nxt = 1'b1;
          head_pay_nxt  = pay_m;
          if (!full) begin
            wr_en         = 1'b1;
            cnt_nxt       = cnt_r + SEQ_W'(1);
            nts_nxt       = nts_r + SEQ_W'(1);
            head_kind_nxt = KIND_SEND;
            head_seq_nxt  = nts_r;
          end else begin
            head_kind_nxt = KIND_DROP;
          end
        end
        CMD_FRAME: begin
          exp_nxt       = exp_r + SEQ_W'(dlv);
          old_nxt       = old_r + rel;
          cnt_nxt       = cnt_r - rel;
          walk_kind_nxt = KIND_STOP;
          walk_left_nxt = rel;
          head_pend_nxt = dlv || (rel == '0);
          if (dlv) begin
            head_kind_nxt = KIND_DELIVER;
            head_seq_nxt  = in_frame_seq;
            head_pay_nxt  = pay_m;
          end
        end
        CMD_CKERR: begin
          head_pend_nxt = 1'b1;
        end
        CMD_TIMEOUT: begin
          nts_nxt       = old_r + cnt_r;
          walk_left_nxt = cnt_r;
          head_pend_nxt = (cnt_r == '0);
        end
        default: begin
          head_pend_nxt = 1'b1;
        end
      endcase
      en_nxt = (cnt_nxt < EFF3);
    end
    if (ctl.emit_head) begin
      head_pend_nxt = 1'b0;
    end
    if (ctl.emit_walk) begin
      walk_ptr_nxt  = walk_ptr_r + SEQ_W'(1);
      walk_left_nxt = walk_left_r - SEQ_W'(1);
    end
  end

  // Form the next result from the head item or the window walk
  always_comb begin
    out_kind_nxt = out_kind_r;
    out_seq_nxt  = out_seq_r;
    out_ack_nxt  = out_ack_r;
    out_pay_nxt  = out_pay_r;
    if (ctl.emit_head) begin
      out_kind_nxt = head_kind_r;
      out_seq_nxt  = head_seq_r;
      out_ack_nxt  = (head_kind_r == KIND_SEND) ? ack_r : '0;
      out_pay_nxt  = '0;
      out_pay_nxt[STORE_W-1:0] = head_pay_r;
    end else if (ctl.emit_walk) begin
      out_kind_nxt = walk_kind_r;
      out_seq_nxt  = walk_ptr_r;
      out_ack_nxt  = (walk_kind_r == KIND_SEND) ? ack_r : '0;
      out_pay_nxt  = '0;
      if (walk_kind_r == KIND_SEND) begin
        out_pay_nxt[STORE_W-1:0] = rd_data_r;
      end
    end
  end

  // Hold window state and plan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nts_r       <= '0;
      old_r       <= '0;
      exp_r       <= '0;
      cnt_r       <= '0;
      head_pend_r <= 1'b0;
      walk_left_r <= '0;
      walk_ptr_r  <= '0;
      en_r        <= 1'b1;
    end else begin
      nts_r       <= nts_nxt;
      old_r       <= old_nxt;
      exp_r       <= exp_nxt;
      cnt_r       <= cnt_nxt;
      head_pend_r <= head_pend_nxt;
      walk_left_r <= walk_left_nxt;
      walk_ptr_r  <= walk_ptr_nxt;
      en_r        <= en_nxt;
    end
  end

  // Hold plan payload fields
  always_ff @(posedge clk) begin
    head_kind_r <= head_kind_nxt;
    head_seq_r  <= head_seq_nxt;
    head_pay_r  <= head_pay_nxt;
    walk_kind_r <= walk_kind_nxt;
    ack_r       <= ack_nxt;
  end

  // Write new packets; read ahead at the next walk position
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[nts_r] <= pay_m;
    end
    rd_data_r <= mem[walk_ptr_nxt];
  end

  // Load the output register on emit
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_ack_r  <= out_ack_nxt;
    out_pay_r  <= out_pay_nxt;
    if (ctl.emit_head || ctl.emit_walk) begin
      out_en_r   <= en_r;
      out_last_r <= ctl.last;
    end
  end

  assign out_kind           = out_kind_r;
  assign out_seq            = out_seq_r;
  assign out_ack            = out_ack_r;
  assign out_payload        = out_pay_r;
  assign out_network_enable = out_en_r;
  assign out_last           = out_last_r;

`ifndef SYNTH
  // Buffered frames always span exactly oldest..next_to_send
  a_window_span: assert property (@(posedge clk) disable iff (!rst_n)
    SEQ_W'(nts_r - old_r) == cnt_r)
    else $error("window pointers disagree with buffered count");

  // The buffered count never exceeds the effective window
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EFF3)
    else $error("buffered count above window");
`endif

endmodule

// ===== sv/go_back_n_window_engine_core.sv =====
// Events are taken only while idle; an event's first result is formed in the run state and held in the output register.
// Throughput: an event yields n results (1 to 8), one result per cycle while the output has room,
//   set by the window walk over the packet store's single read port.
// The input stalls while an event's results are being produced; output stalls pause the walk.
// Reset (rst_n, synchronous, active low) clears pointers, count and handshake state;
//   the packet store is not cleared.
module go_back_n_window_engine_core
  import gbn_pkg::*;
#(
  parameter int WINDOW_MAX   = 7,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [31:0]          in_payload,
  input  logic [SEQ_W-1:0]     in_frame_seq,
  input  logic [SEQ_W-1:0]     in_frame_ack,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_kind,
  output logic [SEQ_W-1:0]     out_seq,
  output logic [SEQ_W-1:0]     out_ack,
  output logic [OUT_PAY_W-1:0] out_payload,
  output logic                 out_network_enable,
  output logic                 out_last
);

  // Window limited by the eight-number sequence space
  localparam int EFF_WIN = (WINDOW_MAX > 7) ? 7 : WINDOW_MAX;
  // Stored payload bits after masking
  localparam int STORE_W = (PAYLOAD_BITS > OUT_PAY_W) ? OUT_PAY_W : PAYLOAD_BITS;

  gbn_ctl_t ctl;
  gbn_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  gbn_dp #(
    .EFF_WIN (EFF_WIN),
    .STORE_W (STORE_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_payload         (in_payload),
    .in_frame_seq       (in_frame_seq),
    .in_frame_ack       (in_frame_ack),
    .out_kind           (out_kind),
    .out_seq            (out_seq),
    .out_ack            (out_ack),
    .out_payload        (out_payload),
    .out_network_enable (out_network_enable),
    .out_last           (out_last)
  );

endmodule
